@@ design/fav_pkg.sv @@
// ---------------------------------------------------------------------------
// fav_pkg: shared types and helpers for the frame altitude vector unit
// Widths, register codes, bundle types and small fixed-point helpers.
// ---------------------------------------------------------------------------
package fav_pkg;

	localparam int ROT_FRAC  = 18;
	localparam int UNIT_FRAC = 26;
	localparam int ROT_W     = 21;
	localparam int ROW_W     = 63;
	localparam int POS_W     = 32;
	localparam int TRANS_W   = 32;
	localparam int TOL_W     = 16;
	localparam int P_W       = 38;
	localparam int F_W       = 37;
	localparam int HALF_W    = 19;
	localparam int SQ_W      = 76;
	localparam int MAG_W     = 39;
	localparam int Q_W       = 27;
	localparam int N_W       = Q_W + 1;
	localparam int DOT_W     = 64 - UNIT_FRAC;
	localparam int OUT_W     = 31;
	localparam int SAT_W     = 40;
	localparam int ADDR_W    = 6;
	localparam int DATA_W    = 64;

	localparam logic [ROW_W-1:0] ROW0_RST = ROW_W'(1) << 18;
	localparam logic [ROW_W-1:0] ROW1_RST = ROW_W'(1) << 39;
	localparam logic [ROW_W-1:0] ROW2_RST = ROW_W'(1) << 60;
	localparam logic [OUT_W-1:0] OUT_MAX  = '1;

	typedef enum logic [2:0] {
		REG_ROW0,
		REG_ROW1,
		REG_ROW2,
		REG_TX,
		REG_TY,
		REG_TZ,
		REG_TOL
	} reg_idx_t;

	typedef struct packed {
		logic [2:0][ROW_W-1:0]   rot_row;
		logic [2:0][TRANS_W-1:0] trans;
		logic [TOL_W-1:0]        tol;
	} cfg_t;

	typedef struct packed {
		logic                  present;
		logic [2:0][POS_W-1:0] parent;
		logic [2:0][POS_W-1:0] emitter;
	} in_t;

	typedef struct packed {
		logic [2:0][P_W-1:0]   p;
		logic [2:0][F_W-1:0]   f;
		logic [2:0][OUT_W-1:0] emit_abs;
		logic [2:0][OUT_W-1:0] fp_abs;
	} geo_t;

	typedef struct packed {
		logic [2:0][F_W-1:0]   f;
		logic [2:0]            psign;
		logic [MAG_W-1:0]      mag;
		logic [2:0][OUT_W-1:0] emit_abs;
		logic [2:0][OUT_W-1:0] fp_abs;
	} div_side_t;

	typedef struct packed {
		logic [2:0][OUT_W-1:0] alt;
		logic [2:0][OUT_W-1:0] emit_abs;
		logic [2:0][OUT_W-1:0] fp_abs;
		logic                  ahead;
	} out_t;

	// signed q2.18 entry of a packed matrix row
	function automatic logic signed [ROT_W-1:0] rot_entry(input logic [ROW_W-1:0] row,
			input int unsigned col);
		return $signed(row[ROT_W*col +: ROT_W]);
	endfunction

	// absolute value clamped to the output range
	function automatic logic [OUT_W-1:0] sat_abs(input logic signed [SAT_W-1:0] x);
		logic [SAT_W-1:0] a;
		a = x[SAT_W-1] ? SAT_W'(-x) : SAT_W'(x);
		return (a > SAT_W'(OUT_MAX)) ? OUT_MAX : a[OUT_W-1:0];
	endfunction

endpackage

@@ design/fav_regs.sv @@
// ---------------------------------------------------------------------------
// fav_regs: configuration register file
// APB-style write and read of the frame matrix, translation and tolerance.
// ---------------------------------------------------------------------------
module fav_regs import fav_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_row[0] <= ROW0_RST;
			cfg_q.rot_row[1] <= ROW1_RST;
			cfg_q.rot_row[2] <= ROW2_RST;
			cfg_q.trans      <= '0;
			cfg_q.tol        <= '0;
		end else if (wr) begin
			case (idx)
				REG_ROW0: cfg_q.rot_row[0] <= pwdata[ROW_W-1:0];
				REG_ROW1: cfg_q.rot_row[1] <= pwdata[ROW_W-1:0];
				REG_ROW2: cfg_q.rot_row[2] <= pwdata[ROW_W-1:0];
				REG_TX:   cfg_q.trans[0]   <= pwdata[TRANS_W-1:0];
				REG_TY:   cfg_q.trans[1]   <= pwdata[TRANS_W-1:0];
				REG_TZ:   cfg_q.trans[2]   <= pwdata[TRANS_W-1:0];
				REG_TOL:  cfg_q.tol        <= pwdata[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ROW0: prdata = DATA_W'(cfg_q.rot_row[0]);
			REG_ROW1: prdata = DATA_W'(cfg_q.rot_row[1]);
			REG_ROW2: prdata = DATA_W'(cfg_q.rot_row[2]);
			REG_TX:   prdata = DATA_W'(cfg_q.trans[0]);
			REG_TY:   prdata = DATA_W'(cfg_q.trans[1]);
			REG_TZ:   prdata = DATA_W'(cfg_q.trans[2]);
			REG_TOL:  prdata = DATA_W'(cfg_q.tol);
			default:  prdata = '0;
		endcase
	end

endmodule

@@ design/fav_xform.sv @@
// ---------------------------------------------------------------------------
// fav_xform: frame transform and squared magnitude
// Five stages: direction, products, rounded sums, partial squares, sum.
// ---------------------------------------------------------------------------
module fav_xform import fav_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  in_t             in_word,
	input  cfg_t            cfg,
	output logic            out_valid,
	output logic [SQ_W-1:0] sq_sum,
	output geo_t            geo
);

	localparam logic signed [55:0] RND_ROT = 56'sd1 <<< (ROT_FRAC - 1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [POS_W:0]   d_c  [3];
	logic signed [POS_W:0]   d_s1 [3];
	logic signed [POS_W-1:0] e_s1 [3];

	logic signed [53:0] prd_s2 [3][3];
	logic signed [52:0] pre_s2 [3][3];

	logic signed [55:0]    ap_c [3];
	logic signed [55:0]    af_c [3];
	logic signed [P_W-1:0] p_s3 [3];
	logic signed [F_W-1:0] f_s3 [3];

	logic [P_W-1:0]          a_c  [3];
	logic [2*(P_W-1-HALF_W)-1:0] hh_s4 [3];
	logic [P_W-2:0]          hl_s4 [3];
	logic [2*HALF_W-1:0]     ll_s4 [3];
	geo_t                    geo_s4;

	logic [SQ_W-1:0] s_c;
	logic [SQ_W-1:0] s_s5;
	geo_t            geo_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// direction parent minus emitter, or minus the emitter when no parent is present
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			d_c[j] = in_word.present ?
				$signed(in_word.parent[j]) - $signed(in_word.emitter[j]) :
				-$signed(in_word.emitter[j]);
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			d_s1[j] <= d_c[j];
			e_s1[j] <= $signed(in_word.emitter[j]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prd_s2[i][j] <= rot_entry(cfg.rot_row[i], j) * d_s1[i];
				pre_s2[i][j] <= rot_entry(cfg.rot_row[i], j) * e_s1[i];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			ap_c[j] = RND_ROT + prd_s2[0][j] + prd_s2[1][j] + prd_s2[2][j];
			af_c[j] = ($signed(cfg.trans[j]) <<< ROT_FRAC) + RND_ROT
				+ pre_s2[0][j] + pre_s2[1][j] + pre_s2[2][j];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			p_s3[j] <= $signed(ap_c[j][ROT_FRAC +: P_W]);
			f_s3[j] <= $signed(af_c[j][ROT_FRAC +: F_W]);
		end
	end

	// |p| split in halves so each square is a narrow product
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			a_c[j] = p_s3[j][P_W-1] ? P_W'(-p_s3[j]) : P_W'(p_s3[j]);
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			hh_s4[j] <= a_c[j][P_W-2:HALF_W] * a_c[j][P_W-2:HALF_W];
			hl_s4[j] <= a_c[j][P_W-2:HALF_W] * a_c[j][HALF_W-1:0];
			ll_s4[j] <= a_c[j][HALF_W-1:0] * a_c[j][HALF_W-1:0];
			geo_s4.p[j]        <= p_s3[j];
			geo_s4.f[j]        <= f_s3[j];
			geo_s4.emit_abs[j] <= sat_abs(f_s3[j]);
			geo_s4.fp_abs[j]   <= sat_abs(f_s3[j] + p_s3[j]);
		end
	end

	always_comb begin
		s_c = '0;
		for (int j = 0; j < 3; j++) begin
			s_c = s_c + (SQ_W'(hh_s4[j]) << (2*HALF_W))
				+ (SQ_W'(hl_s4[j]) << (HALF_W + 1)) + SQ_W'(ll_s4[j]);
		end
	end

	always_ff @(posedge clk) begin
		s_s5   <= s_c;
		geo_s5 <= geo_s4;
	end

	assign out_valid = v_s5;
	assign sq_sum    = s_s5;
	assign geo       = geo_s5;

endmodule

@@ design/fav_sqrt.sv @@
// ---------------------------------------------------------------------------
// fav_sqrt: pipelined integer square root
// One root bit per stage, restoring form, side data carried alongside.
// ---------------------------------------------------------------------------
module fav_sqrt import fav_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [SQ_W-1:0]  sq_sum,
	input  geo_t             geo_in,
	output logic             out_valid,
	output logic [MAG_W-1:0] mag,
	output geo_t             geo_out
);

	localparam int RW = 2*MAG_W + 2;

	logic             v_s    [MAG_W];
	logic [RW-1:0]    rem_s  [MAG_W];
	logic [MAG_W-1:0] root_s [MAG_W];
	geo_t             geo_s  [MAG_W];

	for (genvar k = 0; k < MAG_W; k++) begin : g_bit
		localparam int B = MAG_W - 1 - k;
		logic [RW-1:0]    rem_in;
		logic [RW-1:0]    trial;
		logic [MAG_W-1:0] root_in;
		geo_t             geo_k;
		logic             v_in;

		if (k == 0) begin : g_first
			assign rem_in  = RW'(sq_sum);
			assign root_in = '0;
			assign geo_k   = geo_in;
			assign v_in    = in_valid;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign geo_k   = geo_s[k-1];
			assign v_in    = v_s[k-1];
		end

		// (r + 2^b)^2 - r^2
		assign trial = (RW'(root_in) << (B + 1)) | (RW'(1) << (2*B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			geo_s[k] <= geo_k;
			if (trial <= rem_in) begin
				rem_s[k]  <= rem_in - trial;
				root_s[k] <= root_in | (MAG_W'(1) << B);
			end else begin
				rem_s[k]  <= rem_in;
				root_s[k] <= root_in;
			end
		end
	end

	assign out_valid = v_s[MAG_W-1];
	assign mag       = root_s[MAG_W-1];
	assign geo_out   = geo_s[MAG_W-1];

endmodule

@@ design/fav_div.sv @@
// ---------------------------------------------------------------------------
// fav_div: pipelined unit-vector divider
// Three lanes of rounded |p| * 2^26 / mag, one quotient bit per stage.
// ---------------------------------------------------------------------------
module fav_div import fav_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [MAG_W-1:0]    mag,
	input  geo_t                geo,
	output logic                out_valid,
	output logic [2:0][Q_W-1:0] quo,
	output div_side_t           side
);

	localparam int DW = MAG_W + Q_W;

	logic [P_W-1:0] a_c    [3];
	logic           v_s0;
	logic [DW-1:0]  num_s0 [3];
	div_side_t      side_s0;

	logic           v_s    [Q_W];
	logic [DW-1:0]  rem_s  [Q_W][3];
	logic [Q_W-1:0] q_s    [Q_W][3];
	div_side_t      side_s [Q_W];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			a_c[j] = geo.p[j][P_W-1] ? P_W'(-$signed(geo.p[j])) : geo.p[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else begin
			v_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			num_s0[j]        <= (DW'(a_c[j]) << UNIT_FRAC) + DW'(mag >> 1);
			side_s0.f[j]     <= geo.f[j];
			side_s0.psign[j] <= geo.p[j][P_W-1];
		end
		side_s0.mag      <= mag;
		side_s0.emit_abs <= geo.emit_abs;
		side_s0.fp_abs   <= geo.fp_abs;
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_bit
		localparam int B = Q_W - 1 - k;
		logic [DW-1:0]  rem_in [3];
		logic [Q_W-1:0] q_in   [3];
		div_side_t      side_k;
		logic           v_in;
		logic [DW-1:0]  dsh;

		if (k == 0) begin : g_first
			assign side_k = side_s0;
			assign v_in   = v_s0;
			for (genvar j = 0; j < 3; j++) begin : g_lane
				assign rem_in[j] = num_s0[j];
				assign q_in[j]   = '0;
			end
		end else begin : g_next
			assign side_k = side_s[k-1];
			assign v_in   = v_s[k-1];
			for (genvar j = 0; j < 3; j++) begin : g_lane
				assign rem_in[j] = rem_s[k-1][j];
				assign q_in[j]   = q_s[k-1][j];
			end
		end

		assign dsh = DW'(side_k.mag) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			side_s[k] <= side_k;
			for (int j = 0; j < 3; j++) begin
				if (rem_in[j] >= dsh) begin
					rem_s[k][j] <= rem_in[j] - dsh;
					q_s[k][j]   <= q_in[j] | (Q_W'(1) << B);
				end else begin
					rem_s[k][j] <= rem_in[j];
					q_s[k][j]   <= q_in[j];
				end
			end
		end
	end

	assign out_valid = v_s[Q_W-1];
	assign side      = side_s[Q_W-1];
	assign quo[0]    = q_s[Q_W-1][0];
	assign quo[1]    = q_s[Q_W-1][1];
	assign quo[2]    = q_s[Q_W-1][2];

endmodule

@@ design/fav_proj.sv @@
// ---------------------------------------------------------------------------
// fav_proj: projection and output stage
// Unit vector, dot product, altitude, saturation and the ahead flag.
// ---------------------------------------------------------------------------
module fav_proj import fav_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [2:0][Q_W-1:0] quo,
	input  div_side_t           side,
	input  logic [TOL_W-1:0]    tol,
	output logic                done,
	output out_t                out_word
);

	localparam logic signed [63:0] RND_UNIT = 64'sd1 <<< (UNIT_FRAC - 1);

	logic v_s1, v_s2, v_s3, v_s4;
	logic done_q;
	out_t out_q;

	logic signed [N_W-1:0] n_c  [3];
	logic signed [N_W-1:0] n_s1 [3];
	logic signed [N_W-1:0] n_s2 [3];
	logic signed [N_W-1:0] n_s3 [3];
	div_side_t side_s1, side_s2, side_s3, side_s4;

	logic signed [63:0]      fn_s2 [3];
	logic signed [63:0]      acc_c;
	logic signed [DOT_W-1:0] dot_s3, dot_s4;
	logic signed [63:0]      nd_s4 [3];

	logic signed [63:0]      ndr_c [3];
	logic signed [DOT_W-1:0] pr_c  [3];
	logic signed [MAG_W+1:0] md_c;
	out_t                    out_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			done_q <= v_s4;
		end
	end

	// zero direction gives the zero vector
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (side.mag == '0) begin
				n_c[j] = '0;
			end else if (side.psign[j]) begin
				n_c[j] = -$signed({1'b0, quo[j]});
			end else begin
				n_c[j] = $signed({1'b0, quo[j]});
			end
		end
	end

	always_ff @(posedge clk) begin
		n_s1    <= n_c;
		side_s1 <= side;
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			fn_s2[j] <= $signed(side_s1.f[j]) * n_s1[j];
		end
		n_s2    <= n_s1;
		side_s2 <= side_s1;
	end

	// 64-bit wrapping sum, rounded half up
	assign acc_c = fn_s2[0] + fn_s2[1] + fn_s2[2] + RND_UNIT;

	always_ff @(posedge clk) begin
		dot_s3  <= $signed(acc_c[63:UNIT_FRAC]);
		n_s3    <= n_s2;
		side_s3 <= side_s2;
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			nd_s4[j] <= n_s3[j] * dot_s3;
		end
		dot_s4  <= dot_s3;
		side_s4 <= side_s3;
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			ndr_c[j]        = nd_s4[j] + RND_UNIT;
			pr_c[j]         = $signed(ndr_c[j][63:UNIT_FRAC]);
			out_c.alt[j]    = sat_abs($signed(side_s4.f[j]) - pr_c[j]);
		end
		out_c.emit_abs = side_s4.emit_abs;
		out_c.fp_abs   = side_s4.fp_abs;
		md_c           = $signed({2'b00, side_s4.mag}) + dot_s4;
		out_c.ahead    = ~dot_s4[DOT_W-1]
			| (md_c <= $signed({{(MAG_W+2-TOL_W){1'b0}}, tol}));
	end

	always_ff @(posedge clk) begin
		out_q <= out_c;
	end

	assign done     = done_q;
	assign out_word = out_q;

endmodule

@@ design/frame_altitude_vector_unit.sv @@
// ---------------------------------------------------------------------------
// frame_altitude_vector_unit: altitude of a frame over an emitter line
// each accepted word raises done once it has passed transform, root, divider and projection
// throughput: one word per cycle; busy stays low, the pipeline never stalls
// the 39-stage square root and 28-stage divider set the depth
// reset: arst_n clears all valid bits and loads the identity frame
// ---------------------------------------------------------------------------
module frame_altitude_vector_unit import fav_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	// command side
	input  logic                     start,
	output logic                     busy,
	input  logic                     parent_present,
	input  logic signed [POS_W-1:0]  parent_x,
	input  logic signed [POS_W-1:0]  parent_y,
	input  logic signed [POS_W-1:0]  parent_z,
	input  logic signed [POS_W-1:0]  emitter_x,
	input  logic signed [POS_W-1:0]  emitter_y,
	input  logic signed [POS_W-1:0]  emitter_z,
	// result side, done high for a single cycle per word
	output logic                     done,
	output logic [OUT_W-1:0]         alt_x,
	output logic [OUT_W-1:0]         alt_y,
	output logic [OUT_W-1:0]         alt_z,
	output logic [OUT_W-1:0]         emit_abs_x,
	output logic [OUT_W-1:0]         emit_abs_y,
	output logic [OUT_W-1:0]         emit_abs_z,
	output logic [OUT_W-1:0]         fp_abs_x,
	output logic [OUT_W-1:0]         fp_abs_y,
	output logic [OUT_W-1:0]         fp_abs_z,
	output logic                     ahead
);

	cfg_t                cfg;
	in_t                 in_word;
	logic                accept;

	// transform outputs
	logic                xf_valid;
	logic [SQ_W-1:0]     sq_sum;
	geo_t                xf_geo;

	// square root outputs
	logic                rt_valid;
	logic [MAG_W-1:0]    mag;
	geo_t                rt_geo;

	// divider outputs
	logic                dv_valid;
	logic [2:0][Q_W-1:0] quo;
	div_side_t           dv_side;

	out_t                out_word;

	// every cycle can take a word
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	assign in_word.present    = parent_present;
	assign in_word.parent[0]  = parent_x;
	assign in_word.parent[1]  = parent_y;
	assign in_word.parent[2]  = parent_z;
	assign in_word.emitter[0] = emitter_x;
	assign in_word.emitter[1] = emitter_y;
	assign in_word.emitter[2] = emitter_z;

	// register file
	fav_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// direction and point through the inverse frame, squared length of p
	fav_xform u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_word   (in_word),
		.cfg       (cfg),
		.out_valid (xf_valid),
		.sq_sum    (sq_sum),
		.geo       (xf_geo)
	);

	// magnitude, floor of the root
	fav_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (xf_valid),
		.sq_sum    (sq_sum),
		.geo_in    (xf_geo),
		.out_valid (rt_valid),
		.mag       (mag),
		.geo_out   (rt_geo)
	);

	// unit vector magnitudes, rounded to nearest
	fav_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rt_valid),
		.mag       (mag),
		.geo       (rt_geo),
		.out_valid (dv_valid),
		.quo       (quo),
		.side      (dv_side)
	);

	// dot, perpendicular part and output register
	fav_proj u_proj (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dv_valid),
		.quo      (quo),
		.side     (dv_side),
		.tol      (cfg.tol),
		.done     (done),
		.out_word (out_word)
	);

	assign alt_x      = out_word.alt[0];
	assign alt_y      = out_word.alt[1];
	assign alt_z      = out_word.alt[2];
	assign emit_abs_x = out_word.emit_abs[0];
	assign emit_abs_y = out_word.emit_abs[1];
	assign emit_abs_z = out_word.emit_abs[2];
	assign fp_abs_x   = out_word.fp_abs[0];
	assign fp_abs_y   = out_word.fp_abs[1];
	assign fp_abs_z   = out_word.fp_abs[2];
	assign ahead      = out_word.ahead;

endmodule

@@ tb/frame_altitude_vector_unit_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// frame_altitude_vector_unit_tb: self-checking bench for the altitude unit
// Drives emitter/parent words through the command port, predicts each done
// word in fixed point, and compares every field in order of acceptance.
// ---------------------------------------------------------------------------
module frame_altitude_vector_unit_tb;
	import fav_pkg::*;

	// one predicted done word
	typedef struct {
		longint unsigned alt [3];
		longint unsigned emit_abs [3];
		longint unsigned fp_abs [3];
		bit              ahead;
	} geom_word_t;

	class altitude_board;
		longint unsigned rot_row [3];
		longint          trans [3];
		longint unsigned near_tol;
		geom_word_t      pending [$];
		int              mismatches;

		function new();
			rot_row[0] = 64'(ROW0_RST);
			rot_row[1] = 64'(ROW1_RST);
			rot_row[2] = 64'(ROW2_RST);
			foreach (trans[k]) trans[k] = 0;
			near_tol = 0;
			mismatches = 0;
		endfunction

		// register write as seen on the bus; unknown indexes are dropped
		function void set_reg(int idx, logic [DATA_W-1:0] val);
			if (idx <= REG_ROW2)
				rot_row[idx] = 64'(val[ROW_W-1:0]);
			else if (idx <= REG_TZ)
				trans[idx - REG_TX] = longint'($signed(val[31:0]));
			else if (idx == REG_TOL)
				near_tol = 64'(val[TOL_W-1:0]);
		endfunction

		// round half up by s bits
		function longint round_shift(longint x, int s);
			return (x + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		function longint unsigned clamp_abs(longint x);
			longint unsigned a;
			a = (x < 0) ? longint'(-x) : x;
			return (a > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : a;
		endfunction

		function longint rot_coef(int i, int j);
			logic [ROT_W-1:0] raw;
			raw = ROT_W'(rot_row[i] >> (ROT_W * j));
			return longint'($signed(raw));
		endfunction

		function void note_input(bit present, logic [31:0] par [3], logic [31:0] emt [3]);
			longint e [3], d [3], p [3], f [3], n [3];
			longint ap, af, acc, dot, r;
			logic [127:0] sumsq, root, trial;
			longint unsigned mag, q, pa;
			geom_word_t w;
			sumsq = 0;
			for (int i = 0; i < 3; i++) begin
				e[i] = longint'($signed(emt[i]));
				d[i] = present ? longint'($signed(par[i])) - e[i] : -e[i];
			end
			for (int j = 0; j < 3; j++) begin
				ap = 0;
				af = trans[j] <<< ROT_FRAC;
				for (int i = 0; i < 3; i++) begin
					r = rot_coef(i, j);
					ap += r * d[i];
					af += r * e[i];
				end
				p[j] = round_shift(ap, ROT_FRAC);
				f[j] = round_shift(af, ROT_FRAC);
				pa = (p[j] < 0) ? -p[j] : p[j];
				sumsq += 128'(pa) * 128'(pa);
			end
			// bitwise floor square root
			root = 0;
			for (int b = 38; b >= 0; b--) begin
				trial = root | (128'(1) << b);
				if (trial * trial <= sumsq)
					root = trial;
			end
			mag = root[63:0];
			for (int j = 0; j < 3; j++) begin
				if (mag != 0) begin
					pa = (p[j] < 0) ? -p[j] : p[j];
					q = ((pa << UNIT_FRAC) + mag / 2) / mag;
					n[j] = (p[j] < 0) ? -longint'(q) : longint'(q);
				end else begin
					n[j] = 0;
				end
			end
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += f[j] * n[j];
			dot = round_shift(acc, UNIT_FRAC);
			for (int j = 0; j < 3; j++) begin
				w.alt[j] = clamp_abs(f[j] - round_shift(n[j] * dot, UNIT_FRAC));
				w.emit_abs[j] = clamp_abs(f[j]);
				w.fp_abs[j] = clamp_abs(f[j] + p[j]);
			end
			w.ahead = (dot >= 0) || (longint'(mag) + dot <= longint'(near_tol));
			pending.push_back(w);
		endfunction

		function void check_word(geom_word_t got);
			geom_word_t want;
			bit bad;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected done word at %0t", $realtime);
				return;
			end
			want = pending.pop_front();
			bad = (want.ahead != got.ahead);
			for (int j = 0; j < 3; j++)
				if (want.alt[j] != got.alt[j] || want.emit_abs[j] != got.emit_abs[j]
						|| want.fp_abs[j] != got.fp_abs[j])
					bad = 1;
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch at %0t", $realtime);
					$display("  exp alt %h %h %h emit %h %h %h fp %h %h %h ahead %0d",
						want.alt[0], want.alt[1], want.alt[2], want.emit_abs[0],
						want.emit_abs[1], want.emit_abs[2], want.fp_abs[0],
						want.fp_abs[1], want.fp_abs[2], want.ahead);
					$display("  got alt %h %h %h emit %h %h %h fp %h %h %h ahead %0d",
						got.alt[0], got.alt[1], got.alt[2], got.emit_abs[0],
						got.emit_abs[1], got.emit_abs[2], got.fp_abs[0],
						got.fp_abs[1], got.fp_abs[2], got.ahead);
				end
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic start = 0;
	logic busy;
	logic parent_present = 0;
	logic signed [POS_W-1:0] parent_x = '0, parent_y = '0, parent_z = '0;
	logic signed [POS_W-1:0] emitter_x = '0, emitter_y = '0, emitter_z = '0;
	logic done;
	logic [OUT_W-1:0] alt_x, alt_y, alt_z;
	logic [OUT_W-1:0] emit_abs_x, emit_abs_y, emit_abs_z;
	logic [OUT_W-1:0] fp_abs_x, fp_abs_y, fp_abs_z;
	logic ahead;

	altitude_board board = new();
	int sender_idle_pct = 0;

	frame_altitude_vector_unit u_top (.*);

	// 20 ns period
	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// acceptance: values seen here are the ones present before the edge
	always @(posedge clk) begin
		logic [31:0] par [3], emt [3];
		if (arst_n && start && !busy) begin
			par = '{parent_x, parent_y, parent_z};
			emt = '{emitter_x, emitter_y, emitter_z};
			board.note_input(parent_present, par, emt);
		end
	end

	// done words cannot be held off, so each one is checked on its strobe
	always @(posedge clk) begin
		geom_word_t got;
		if (arst_n && done) begin
			got.alt = '{64'(alt_x), 64'(alt_y), 64'(alt_z)};
			got.emit_abs = '{64'(emit_abs_x), 64'(emit_abs_y), 64'(emit_abs_z)};
			got.fp_abs = '{64'(fp_abs_x), 64'(fp_abs_y), 64'(fp_abs_z)};
			got.ahead = ahead;
			board.check_word(got);
		end
	end

	// hard stop well past the slowest legal run
	initial begin
		#10ms;
		$display("frame_altitude_vector_unit verification failed");
		$finish;
	end

	// setup then access; the write lands on the access edge
	task automatic reg_write(int idx, logic [DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= ADDR_W'(8 * idx);
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		board.set_reg(idx, val);
	endtask

	// pipeline fully empty: all expected words back plus the pipeline depth
	task automatic drain();
		@(posedge clk);
		start <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (90) @(posedge clk);
	endtask

	task automatic send_word(bit present, logic [31:0] par [3], logic [31:0] emt [3]);
		logic held;
		// random sender gaps, short so the run stays bounded
		if ($urandom_range(99) < sender_idle_pct) begin
			@(posedge clk);
			start <= 0;
			repeat ($urandom_range(6)) @(posedge clk);
		end
		@(posedge clk);
		start <= 1;
		parent_present <= present;
		parent_x <= par[0];
		parent_y <= par[1];
		parent_z <= par[2];
		emitter_x <= emt[0];
		emitter_y <= emt[1];
		emitter_z <= emt[2];
		do begin
			@(negedge clk);
			held = busy;
		end while (held);
	endtask

	function automatic logic [31:0] rand_coord(int style);
		case (style)
			0: return $urandom();
			1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
			2: return 32'($signed($urandom_range(200)) - 100);
			default: begin
				case ($urandom_range(3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	function automatic logic [ROW_W-1:0] rand_row();
		logic [ROW_W-1:0] row;
		row = ROW_W'({$urandom(), $urandom()});
		// mostly near-unit entries, sometimes full-range junk
		if ($urandom_range(3) != 0)
			for (int c = 0; c < 3; c++)
				row[ROT_W*c +: ROT_W] = ROT_W'($signed($urandom_range(524288)) - 262144);
		return row;
	endfunction

	task automatic random_words(int count);
		logic [31:0] par [3], emt [3];
		int style;
		bit present;
		repeat (count) begin
			style = $urandom_range(4);
			present = $urandom_range(1);
			for (int k = 0; k < 3; k++) begin
				emt[k] = rand_coord(style == 4 ? $urandom_range(3) : style);
				par[k] = rand_coord(style == 4 ? $urandom_range(3) : style);
			end
			// zero direction now and then
			if ($urandom_range(15) == 0)
				par = emt;
			if ($urandom_range(31) == 0 && !present)
				emt = '{0, 0, 0};
			send_word(present, par, emt);
		end
	endtask

	task automatic directed_words();
		logic [31:0] par [3], emt [3];
		logic [31:0] ext [4];
		ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
		foreach (ext[a]) begin
			emt = '{ext[a], ext[a], ext[a]};
			par = '{ext[3-a], ext[a], ext[(a+1)%4]};
			send_word(1, par, emt);
			send_word(0, par, emt);
		end
		// zero direction: parent on the emitter, and no parent with emitter at origin
		emt = '{32'h0001_0000, 32'hFFFE_0000, 32'h0003_8000};
		send_word(1, emt, emt);
		send_word(0, '{32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF}, '{0, 0, 0});
		// behind the emitter and just in front
		send_word(1, '{32'h0010_0000, 0, 0}, '{32'h0020_0000, 32'h0001_0000, 0});
		send_word(1, '{32'hFFF0_0000, 0, 0}, '{32'h0000_0001, 32'h0000_0001, 1});
		send_word(1, '{32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333},
			'{32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC});
	endtask

	initial begin
		int phase_idle [4];
		phase_idle = '{0, 68, 0, 37};
		repeat (11) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		// reset frame first
		directed_words();
		random_words(150);
		drain();

		// extremes of every register, plus an index past the list
		for (int r = REG_ROW0; r <= REG_ROW2; r++)
			reg_write(r, {1'b0, {ROW_W{1'b1}}} & {ROW_W'({3{1'b0, 20'hFFFFF}})});
		reg_write(REG_TX, 64'h7FFF_FFFF);
		reg_write(REG_TY, 64'hFFFF_FFFF_8000_0000);
		reg_write(REG_TZ, 64'h0);
		reg_write(REG_TOL, 64'hFFFF);
		reg_write(7, 64'hFFFF_FFFF_FFFF_FFFF);
		directed_words();
		random_words(100);
		drain();

		reg_write(REG_ROW0, {1'b0, {3{1'b1, 20'h0}}});
		reg_write(REG_ROW1, {1'b0, {3{21'h100000}}});
		reg_write(REG_ROW2, 64'hFFFF_FFFF_FFFF_FFFF);
		reg_write(REG_TOL, 64'h0);
		reg_write(REG_TX, 64'hFFFF_FFFF_8000_0000);
		directed_words();
		random_words(100);
		drain();

		// random frames across the sender idle phases
		for (int ph = 0; ph < 8; ph++) begin
			sender_idle_pct = phase_idle[ph % 4];
			for (int r = REG_ROW0; r <= REG_ROW2; r++)
				reg_write(r, rand_row());
			for (int r = REG_TX; r <= REG_TZ; r++)
				reg_write(r, {$urandom(), $urandom()} >>> $urandom_range(40));
			reg_write(REG_TOL, ($urandom_range(1)) ? 64'($urandom_range(65535)) : 64'h0);
			random_words(180);
			drain();
		end

		wait (board.pending.size() == 0);
		repeat (100) @(posedge clk);
		if (board.mismatches == 0)
			$display("frame_altitude_vector_unit verification clean");
		else
			$display("frame_altitude_vector_unit verification failed");
		$finish;
	end

endmodule
